@@ design/assert_macros.svh @@
// assertion macros shared by the drivetrain rtl
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, disabled while reset is low
`define CHK_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// implication check, consequent checked in the cycle after the antecedent
`define CHK_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/tmdrk_pkg.sv @@
// types, constants and the step program of the two-mass drivetrain integrator
// no dependencies
package tmdrk_pkg;

    localparam int W = 48;
    localparam int F = 24;
    localparam int H = W / 2;
    localparam int CFG_W = 47;
    localparam int TS_W = 25;
    localparam int MEM_DEPTH = 32;

    localparam logic signed [W-1:0] VMAX = {1'b0, {(W-1){1'b1}}};
    localparam logic signed [W-1:0] VMIN = {1'b1, {(W-1){1'b0}}};
    localparam logic [W-1:0] ONE = W'(1) << F;
    localparam logic [W-1:0] SIXTH = W'(((64'd1 << F) + 64'd3) / 64'd6);

    typedef struct packed {
        logic                kind;
        logic signed [W-1:0] rotor_tq;
        logic signed [W-1:0] gen_tq;
        logic signed [W-1:0] initial_rotor_speed;
    } t_in_item;

    typedef struct packed {
        logic signed [W-1:0] rotor_angle;
        logic signed [W-1:0] rotor_speed;
        logic signed [W-1:0] gen_angle;
        logic signed [W-1:0] gen_speed;
    } t_out_item;

    // register indexes
    localparam logic [2:0] REG_MODE = 3'd0;
    localparam logic [2:0] REG_TS   = 3'd1;
    localparam logic [2:0] REG_GR   = 3'd2;
    localparam logic [2:0] REG_IGR  = 3'd3;
    localparam logic [2:0] REG_K    = 3'd4;
    localparam logic [2:0] REG_D    = 3'd5;
    localparam logic [2:0] REG_IRI  = 3'd6;
    localparam logic [2:0] REG_IGI  = 3'd7;

    // operations of the shared unit
    localparam logic [2:0] OP_MOV  = 3'd0;
    localparam logic [2:0] OP_ADD  = 3'd1;
    localparam logic [2:0] OP_SUB  = 3'd2;
    localparam logic [2:0] OP_NEG  = 3'd3;
    localparam logic [2:0] OP_HALF = 3'd4;
    localparam logic [2:0] OP_MUL  = 3'd5;

    // operand codes: bit 5 set selects the scratch memory
    localparam logic [5:0] S_ZERO  = 6'd0;
    localparam logic [5:0] S_RA    = 6'd1;
    localparam logic [5:0] S_RV    = 6'd2;
    localparam logic [5:0] S_GA    = 6'd3;
    localparam logic [5:0] S_GV    = 6'd4;
    localparam logic [5:0] S_TS    = 6'd5;
    localparam logic [5:0] S_GR    = 6'd6;
    localparam logic [5:0] S_IGR   = 6'd7;
    localparam logic [5:0] S_K     = 6'd8;
    localparam logic [5:0] S_D     = 6'd9;
    localparam logic [5:0] S_IRI   = 6'd10;
    localparam logic [5:0] S_IGI   = 6'd11;
    localparam logic [5:0] S_SIXTH = 6'd12;
    localparam logic [5:0] S_RT    = 6'd13;
    localparam logic [5:0] S_GT    = 6'd14;
    localparam logic [5:0] S_IRS   = 6'd15;

    localparam logic [5:0] M_BRA  = 6'h20;
    localparam logic [5:0] M_BRV  = 6'h21;
    localparam logic [5:0] M_BGA  = 6'h22;
    localparam logic [5:0] M_BGV  = 6'h23;
    localparam logic [5:0] M_SRA  = 6'h24;
    localparam logic [5:0] M_SRV  = 6'h25;
    localparam logic [5:0] M_SGA  = 6'h26;
    localparam logic [5:0] M_SGV  = 6'h27;
    localparam logic [5:0] M_GAR  = 6'h28;
    localparam logic [5:0] M_GVR  = 6'h29;
    localparam logic [5:0] M_T    = 6'h2A;
    localparam logic [5:0] M_R    = 6'h2B;
    localparam logic [5:0] M_G    = 6'h2C;
    localparam logic [5:0] M_RACC = 6'h2D;
    localparam logic [5:0] M_GACC = 6'h2E;
    localparam logic [5:0] M_DRV  = 6'h2F;
    localparam logic [5:0] M_DRA  = 6'h30;
    localparam logic [5:0] M_DGV  = 6'h31;
    localparam logic [5:0] M_DGA  = 6'h32;

    // program addresses the sequencer branches on
    localparam logic [5:0] PC_STEP  = 6'd0;
    localparam logic [5:0] PC_STAGE = 6'd8;
    localparam logic [5:0] PC_MCHK  = 6'd9;
    localparam logic [5:0] PC_DT    = 6'd28;
    localparam logic [5:0] PC_ACC   = 6'd32;
    localparam logic [5:0] PC_ACCE  = 6'd35;
    localparam logic [5:0] PC_HALF  = 6'd36;
    localparam logic [5:0] PC_BASE  = 6'd40;
    localparam logic [5:0] PC_BASEE = 6'd43;
    localparam logic [5:0] PC_FIN   = 6'd44;
    localparam logic [5:0] PC_FINE  = 6'd51;
    localparam logic [5:0] PC_LOAD  = 6'd52;
    localparam logic [5:0] PC_LOADE = 6'd55;
    localparam logic [5:0] PC_LMUL  = 6'd56;

    typedef struct packed {
        logic [2:0] op;
        logic [5:0] dst;
        logic [5:0] a;
        logic [5:0] b;
    } t_instr;

    function automatic t_instr prog(input logic [5:0] pc);
        t_instr r;
        unique case (pc)
            // step setup: bases from the state, sums cleared
            6'd0:  r = '{OP_MOV, M_BRA, S_RA, S_ZERO};
            6'd1:  r = '{OP_MOV, M_BRV, S_RV, S_ZERO};
            6'd2:  r = '{OP_MOV, M_BGA, S_GA, S_ZERO};
            6'd3:  r = '{OP_MOV, M_BGV, S_GV, S_ZERO};
            6'd4:  r = '{OP_MOV, M_SRA, S_ZERO, S_ZERO};
            6'd5:  r = '{OP_MOV, M_SRV, S_ZERO, S_ZERO};
            6'd6:  r = '{OP_MOV, M_SGA, S_ZERO, S_ZERO};
            6'd7:  r = '{OP_MOV, M_SGV, S_ZERO, S_ZERO};
            // stage: accelerations default to zero
            6'd8:  r = '{OP_MOV, M_RACC, S_ZERO, S_ZERO};
            6'd9:  r = '{OP_MOV, M_GACC, S_ZERO, S_ZERO};
            6'd10: r = '{OP_MUL, M_GAR, M_BGA, S_IGR};
            6'd11: r = '{OP_MUL, M_GVR, M_BGV, S_IGR};
            6'd12: r = '{OP_SUB, M_T, M_GAR, M_BRA};
            6'd13: r = '{OP_MUL, M_T, S_K, M_T};
            6'd14: r = '{OP_ADD, M_R, S_RT, M_T};
            6'd15: r = '{OP_SUB, M_T, M_GVR, M_BRV};
            6'd16: r = '{OP_MUL, M_T, S_D, M_T};
            6'd17: r = '{OP_ADD, M_R, M_R, M_T};
            6'd18: r = '{OP_MUL, M_RACC, M_R, S_IRI};
            6'd19: r = '{OP_MUL, M_T, S_GR, S_GT};
            6'd20: r = '{OP_NEG, M_G, M_T, S_ZERO};
            6'd21: r = '{OP_SUB, M_T, M_BRA, M_GAR};
            6'd22: r = '{OP_MUL, M_T, S_K, M_T};
            6'd23: r = '{OP_ADD, M_G, M_G, M_T};
            6'd24: r = '{OP_SUB, M_T, M_BRV, M_GVR};
            6'd25: r = '{OP_MUL, M_T, S_D, M_T};
            6'd26: r = '{OP_ADD, M_G, M_G, M_T};
            6'd27: r = '{OP_MUL, M_GACC, M_G, S_IGI};
            6'd28: r = '{OP_MUL, M_DRV, M_RACC, S_TS};
            6'd29: r = '{OP_MUL, M_DRA, M_BRV, S_TS};
            6'd30: r = '{OP_MUL, M_DGV, M_GACC, S_TS};
            6'd31: r = '{OP_MUL, M_DGA, M_BGV, S_TS};
            6'd32: r = '{OP_ADD, M_SRV, M_SRV, M_DRV};
            6'd33: r = '{OP_ADD, M_SRA, M_SRA, M_DRA};
            6'd34: r = '{OP_ADD, M_SGV, M_SGV, M_DGV};
            6'd35: r = '{OP_ADD, M_SGA, M_SGA, M_DGA};
            6'd36: r = '{OP_HALF, M_DRV, M_DRV, S_ZERO};
            6'd37: r = '{OP_HALF, M_DRA, M_DRA, S_ZERO};
            6'd38: r = '{OP_HALF, M_DGV, M_DGV, S_ZERO};
            6'd39: r = '{OP_HALF, M_DGA, M_DGA, S_ZERO};
            6'd40: r = '{OP_ADD, M_BRV, S_RV, M_DRV};
            6'd41: r = '{OP_ADD, M_BRA, S_RA, M_DRA};
            6'd42: r = '{OP_ADD, M_BGV, S_GV, M_DGV};
            6'd43: r = '{OP_ADD, M_BGA, S_GA, M_DGA};
            // weighted sums times one sixth into the state
            6'd44: r = '{OP_MUL, M_T, M_SRV, S_SIXTH};
            6'd45: r = '{OP_ADD, S_RV, S_RV, M_T};
            6'd46: r = '{OP_MUL, M_T, M_SRA, S_SIXTH};
            6'd47: r = '{OP_ADD, S_RA, S_RA, M_T};
            6'd48: r = '{OP_MUL, M_T, M_SGV, S_SIXTH};
            6'd49: r = '{OP_ADD, S_GV, S_GV, M_T};
            6'd50: r = '{OP_MUL, M_T, M_SGA, S_SIXTH};
            6'd51: r = '{OP_ADD, S_GA, S_GA, M_T};
            // load item
            6'd52: r = '{OP_MOV, S_RV, S_IRS, S_ZERO};
            6'd53: r = '{OP_MOV, S_RA, S_ZERO, S_ZERO};
            6'd54: r = '{OP_MOV, S_GA, S_ZERO, S_ZERO};
            6'd55: r = '{OP_MOV, S_GV, S_ZERO, S_ZERO};
            6'd56: r = '{OP_MUL, S_GV, S_IRS, S_GR};
            default: r = '{OP_MOV, M_T, S_ZERO, S_ZERO};
        endcase
        return r;
    endfunction

endpackage

@@ design/two_mass_drivetrain_rk4_step.sv @@
// two-mass drivetrain, one rk4 step per step item, microcoded on one shared unit
// depends on tmdrk_pkg and assert_macros.svh
//
// Usage: input items arrive on i_in_valid / o_in_stall / i_in_item, results
// leave on o_out_valid / i_out_stall / o_out_item. An item with kind 0 runs one
// rk4 step with the given torques; kind 1 reloads the rotor speed and clears
// the angles. Every item gives exactly one result: the shaft state after it.
// Registers are written over the apb port; the user must write them only
// while the block is idle, the block itself does not enforce this.
// A small sequencer runs a program on one saturating alu and one
// 24x24 multiplier. Each program word reads its operands from the
// scratch memory, then executes; a multiply adds setup, 4 partial
// products and rounding.
// One item is in work at a time; o_in_stall is high from acceptance until the
// result is handed to the output register.
// A new item is taken while the previous result still waits; if the receiver
// stalls, the finished result waits in the core until the output is free.
// Reset: state and angles zero, mode constant speed, ratios and inertias 1.0.
module two_mass_drivetrain_rk4_step
    import tmdrk_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  t_in_item         i_in_item,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output t_out_item        o_out_item,
    input  logic             psel,
    input  logic             penable,
    input  logic             pwrite,
    input  logic [5:0]       paddr,
    input  logic [63:0]      pwdata,
    output logic [63:0]      prdata,
    output logic             pready
);

`include "assert_macros.svh"

    localparam logic [2:0] P_IDLE  = 3'd0;
    localparam logic [2:0] P_FETCH = 3'd1;
    localparam logic [2:0] P_EXEC  = 3'd2;
    localparam logic [2:0] P_MUL   = 3'd3;
    localparam logic [2:0] P_MFIN  = 3'd4;
    localparam logic [2:0] P_HOLD  = 3'd5;

    localparam int QW = 2 * W - F;

    // configuration
    logic             r_mode;
    logic [TS_W-1:0]  r_ts;
    logic [CFG_W-1:0] r_gr, r_igr, r_k, r_d, r_iri, r_igi;

    // state and item
    logic signed [W-1:0] r_ra, r_rv, r_ga, r_gv;
    t_in_item            r_item;
    t_out_item           r_out;
    logic                r_out_valid;

    // sequencer
    logic [2:0] r_phase;
    logic [5:0] r_pc;
    logic [1:0] r_stage;
    logic       r_rep;

    // scratch memory
    logic [W-1:0] r_mem [MEM_DEPTH];
    logic [W-1:0] r_rda, r_rdb;

    // multiplier
    logic [W-1:0]   r_ma, r_mb;
    logic           r_neg;
    logic [2*W-1:0] r_acc;
    logic [1:0]     r_cnt;

    t_instr ins;
    logic   cfg_wr, in_acc, out_acc, hold_go;
    logic signed [W-1:0] opa, opb, alu_res, mul_res, wr_data;
    logic   wr_en, ins_done;
    logic [5:0] n_pc;
    logic [1:0] n_stage;
    logic       n_rep, n_fin;

    assign ins     = prog(r_pc);
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign o_in_stall = (r_phase != P_IDLE);
    assign in_acc  = i_in_valid && !o_in_stall;
    assign out_acc = r_out_valid && !i_out_stall;
    assign hold_go = (r_phase == P_HOLD) && (!r_out_valid || !i_out_stall);
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    function automatic logic signed [W-1:0] sel_opnd(input logic [5:0] c,
                                                     input logic [W-1:0] md,
                                                     input logic signed [W-1:0] ra,
                                                     input logic signed [W-1:0] rv,
                                                     input logic signed [W-1:0] ga,
                                                     input logic signed [W-1:0] gv,
                                                     input t_in_item it,
                                                     input logic [TS_W-1:0] ts,
                                                     input logic [CFG_W-1:0] gr,
                                                     input logic [CFG_W-1:0] igr,
                                                     input logic [CFG_W-1:0] k,
                                                     input logic [CFG_W-1:0] d,
                                                     input logic [CFG_W-1:0] iri,
                                                     input logic [CFG_W-1:0] igi);
        logic signed [W-1:0] v;
        priority if (c[5]) begin
            v = md;
        end else begin
            unique case (c)
                S_RA:    v = ra;
                S_RV:    v = rv;
                S_GA:    v = ga;
                S_GV:    v = gv;
                S_TS:    v = W'(ts);
                S_GR:    v = W'(gr);
                S_IGR:   v = W'(igr);
                S_K:     v = W'(k);
                S_D:     v = W'(d);
                S_IRI:   v = W'(iri);
                S_IGI:   v = W'(igi);
                S_SIXTH: v = SIXTH;
                S_RT:    v = it.rotor_tq;
                S_GT:    v = it.gen_tq;
                S_IRS:   v = it.initial_rotor_speed;
                default: v = '0;
            endcase
        end
        return v;
    endfunction

    assign opa = sel_opnd(ins.a, r_rda, r_ra, r_rv, r_ga, r_gv, r_item, r_ts, r_gr,
                          r_igr, r_k, r_d, r_iri, r_igi);
    assign opb = sel_opnd(ins.b, r_rdb, r_ra, r_rv, r_ga, r_gv, r_item, r_ts, r_gr,
                          r_igr, r_k, r_d, r_iri, r_igi);

    // saturating alu
    logic signed [W:0] sum_x, dif_x;
    always_comb begin
        sum_x = {opa[W-1], opa} + {opb[W-1], opb};
        dif_x = {opa[W-1], opa} - {opb[W-1], opb};
        unique case (ins.op)
            OP_ADD:  alu_res = (sum_x[W] != sum_x[W-1]) ? (sum_x[W] ? VMIN : VMAX)
                                                        : sum_x[W-1:0];
            OP_SUB:  alu_res = (dif_x[W] != dif_x[W-1]) ? (dif_x[W] ? VMIN : VMAX)
                                                        : dif_x[W-1:0];
            OP_NEG:  alu_res = (opa == VMIN) ? VMAX : -opa;
            OP_HALF: alu_res = opa >>> 1;
            default: alu_res = opa;
        endcase
    end

    // multiply rounding: floor of the signed product, then saturate
    logic [QW-1:0] q, qn;
    logic          rem;
    always_comb begin
        q   = r_acc[2*W-1:F];
        rem = |r_acc[F-1:0];
        qn  = q + QW'(rem);
        if (r_neg) begin
            mul_res = (|qn[QW-1:W-1]) ? VMIN : -$signed(qn[W-1:0]);
        end else begin
            mul_res = (|q[QW-1:W-1]) ? VMAX : $signed(q[W-1:0]);
        end
    end

    logic [W-1:0]   pp;
    logic [2*W-1:0] pp_sh;
    logic [1:0]     pp_pos;
    always_comb begin
        pp     = W'(r_ma[r_cnt[1]*H +: H] * r_mb[r_cnt[0]*H +: H]);
        pp_pos = {1'b0, r_cnt[1]} + {1'b0, r_cnt[0]};
        pp_sh  = {{W{1'b0}}, pp} << (pp_pos * H);
    end

    assign wr_en = ((r_phase == P_EXEC) && (ins.op != OP_MUL)) || (r_phase == P_MFIN);
    assign wr_data = (r_phase == P_MFIN) ? mul_res : alu_res;

    // next program word once the current one completes
    always_comb begin
        n_pc    = r_pc + 6'd1;
        n_stage = r_stage;
        n_rep   = r_rep;
        n_fin   = 1'b0;
        priority if (r_pc == PC_MCHK) begin
            n_pc = r_mode ? PC_DT : PC_MCHK + 6'd1;
        end else if (r_pc == PC_ACCE) begin
            // middle stages count twice
            if ((r_stage == 2'd1 || r_stage == 2'd2) && !r_rep) begin
                n_pc  = PC_ACC;
                n_rep = 1'b1;
            end else begin
                n_rep = 1'b0;
                n_pc  = (r_stage < 2'd2) ? PC_HALF : PC_BASE;
            end
        end else if (r_pc == PC_BASEE) begin
            if (r_stage == 2'd3) begin
                n_pc = PC_FIN;
            end else begin
                n_pc    = PC_STAGE;
                n_stage = r_stage + 2'd1;
            end
        end else if (r_pc == PC_FINE || r_pc == PC_LMUL) begin
            n_fin = 1'b1;
        end else if (r_pc == PC_LOADE) begin
            n_fin = r_mode;
            n_pc  = PC_LMUL;
        end
    end

    assign ins_done = wr_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= P_IDLE;
            r_pc        <= PC_STEP;
            r_stage     <= '0;
            r_rep       <= 1'b0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (hold_go) begin
                r_out_valid <= 1'b1;
            end else if (out_acc) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_phase)
                P_IDLE: begin
                    if (in_acc) begin
                        r_phase <= P_FETCH;
                        r_stage <= '0;
                        r_rep   <= 1'b0;
                        r_pc    <= i_in_item.kind ? PC_LOAD : PC_STEP;
                    end
                end
                P_FETCH: r_phase <= P_EXEC;
                P_EXEC: begin
                    if (ins.op == OP_MUL) begin
                        r_phase <= P_MUL;
                        r_cnt   <= '0;
                    end else begin
                        r_phase <= n_fin ? P_HOLD : P_FETCH;
                        r_pc    <= n_pc;
                        r_stage <= n_stage;
                        r_rep   <= n_rep;
                    end
                end
                P_MUL: begin
                    r_cnt <= r_cnt + 2'd1;
                    if (r_cnt == 2'd3) begin
                        r_phase <= P_MFIN;
                    end
                end
                P_MFIN: begin
                    r_phase <= n_fin ? P_HOLD : P_FETCH;
                    r_pc    <= n_pc;
                    r_stage <= n_stage;
                    r_rep   <= n_rep;
                end
                P_HOLD: begin
                    if (hold_go) begin
                        r_phase <= P_IDLE;
                    end
                end
                default: r_phase <= P_IDLE;
            endcase
        end
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ra <= '0;
            r_rv <= '0;
            r_ga <= '0;
            r_gv <= '0;
        end else if (wr_en && !ins.dst[5]) begin
            unique case (ins.dst)
                S_RA:    r_ra <= wr_data;
                S_RV:    r_rv <= wr_data;
                S_GA:    r_ga <= wr_data;
                S_GV:    r_gv <= wr_data;
                default: ;
            endcase
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= 1'b1;
            r_ts   <= '0;
            r_gr   <= CFG_W'(ONE);
            r_igr  <= CFG_W'(ONE);
            r_k    <= '0;
            r_d    <= '0;
            r_iri  <= CFG_W'(ONE);
            r_igi  <= CFG_W'(ONE);
        end else if (cfg_wr) begin
            unique case (paddr[5:3])
                REG_MODE: r_mode <= pwdata[0];
                REG_TS:   r_ts   <= pwdata[TS_W-1:0];
                REG_GR:   r_gr   <= pwdata[CFG_W-1:0];
                REG_IGR:  r_igr  <= pwdata[CFG_W-1:0];
                REG_K:    r_k    <= pwdata[CFG_W-1:0];
                REG_D:    r_d    <= pwdata[CFG_W-1:0];
                REG_IRI:  r_iri  <= pwdata[CFG_W-1:0];
                REG_IGI:  r_igi  <= pwdata[CFG_W-1:0];
                default:  ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[5:3])
            REG_MODE: prdata = 64'(r_mode);
            REG_TS:   prdata = 64'(r_ts);
            REG_GR:   prdata = 64'(r_gr);
            REG_IGR:  prdata = 64'(r_igr);
            REG_K:    prdata = 64'(r_k);
            REG_D:    prdata = 64'(r_d);
            REG_IRI:  prdata = 64'(r_iri);
            REG_IGI:  prdata = 64'(r_igi);
            default:  prdata = '0;
        endcase
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_item <= i_in_item;
        end
        if (hold_go) begin
            r_out <= '{rotor_angle: r_ra, rotor_speed: r_rv,
                       gen_angle: r_ga, gen_speed: r_gv};
        end
        if (r_phase == P_FETCH) begin
            r_rda <= r_mem[ins.a[4:0]];
            r_rdb <= r_mem[ins.b[4:0]];
        end
        if (wr_en && ins.dst[5]) begin
            r_mem[ins.dst[4:0]] <= wr_data;
        end
    end

    // serial multiplier on magnitudes
    always_ff @(posedge i_clk) begin
        if (r_phase == P_EXEC && ins.op == OP_MUL) begin
            r_ma  <= opa[W-1] ? W'(-opa) : opa;
            r_mb  <= opb[W-1] ? W'(-opb) : opb;
            r_neg <= opa[W-1] ^ opb[W-1];
            r_acc <= '0;
        end else if (r_phase == P_MUL) begin
            r_acc <= r_acc + pp_sh;
        end
    end

    `CHK_ASSERT(a_out_from_hold, i_clk, i_rst_n,
        $rose(r_out_valid) |-> $past(r_phase == P_HOLD), "result without finished item")
    `CHK_NEXT(a_accept_starts, i_clk, i_rst_n, in_acc, r_phase == P_FETCH,
        "accepted item did not start")
    `CHK_NEXT(a_hold_waits, i_clk, i_rst_n,
        (r_phase == P_HOLD) && r_out_valid && i_out_stall, r_phase == P_HOLD,
        "result overwrote a stalled output")
    `CHK_ASSERT(a_done_once, i_clk, i_rst_n,
        ins_done |-> (r_phase == P_EXEC || r_phase == P_MFIN), "write outside execute")

endmodule

@@ tb/sv/testbench.sv @@
// self-checking testbench for the two-mass drivetrain rk4 integrator
// drives items, apb register writes and output stalls; predicts every result itself
// depends on tmdrk_pkg and two_mass_drivetrain_rk4_step
module testbench
    import tmdrk_pkg::*;
();

    typedef logic signed [W-1:0] t_word;

    localparam int WDOG_LIMIT = 40000;
    localparam int REG_WIDTH [8] = '{1, TS_W, CFG_W, CFG_W, CFG_W, CFG_W, CFG_W, CFG_W};
    localparam t_word HALF_C = t_word'(1) <<< (F - 1);

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    t_in_item    i_in_item = '0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    t_out_item   o_out_item;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [5:0]  paddr = '0;
    logic [63:0] pwdata = '0;
    logic [63:0] prdata;
    logic        pready;

    two_mass_drivetrain_rk4_step u_top (.*);

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // predictor copy of the registers and the shaft state
    t_word     cfg_val [8];
    t_word     st_ra, st_rv, st_ga, st_gv;
    t_out_item shaft_q [$];
    int        mismatches = 0;
    bit        calm = 1'b0;
    int        quiet_cycles = 0;

    function automatic t_word sat(input logic signed [127:0] x);
        if (x > 128'(VMAX)) return VMAX;
        if (x < 128'(VMIN)) return VMIN;
        return t_word'(x);
    endfunction

    function automatic t_word qmul(input t_word a, input t_word b);
        logic signed [127:0] x, y, p;
        x = a;
        y = b;
        p = (x * y) >>> F;
        return sat(p);
    endfunction

    function automatic t_word qadd(input t_word a, input t_word b);
        logic signed [127:0] x, y;
        x = a;
        y = b;
        return sat(x + y);
    endfunction

    function automatic t_word qsub(input t_word a, input t_word b);
        logic signed [127:0] x, y;
        x = a;
        y = b;
        return sat(x - y);
    endfunction

    // shaft accelerations for one stage base
    function automatic void shaft_accel(input t_word ra, rv, ga, gv, rt, gt,
                                        output t_word racc, gacc);
        t_word ga_r, gv_r, r, g;
        if (cfg_val[REG_MODE] != 0) begin
            racc = '0;
            gacc = '0;
            return;
        end
        ga_r = qmul(ga, cfg_val[REG_IGR]);
        gv_r = qmul(gv, cfg_val[REG_IGR]);
        r = qadd(rt, qmul(cfg_val[REG_K], qsub(ga_r, ra)));
        r = qadd(r, qmul(cfg_val[REG_D], qsub(gv_r, rv)));
        racc = qmul(r, cfg_val[REG_IRI]);
        g = qmul(cfg_val[REG_GR], gt);
        g = (g == VMIN) ? VMAX : -g;
        g = qadd(g, qmul(cfg_val[REG_K], qsub(ra, ga_r)));
        g = qadd(g, qmul(cfg_val[REG_D], qsub(rv, gv_r)));
        gacc = qmul(g, cfg_val[REG_IGI]);
    endfunction

    function automatic t_out_item advance_shafts(input t_in_item it);
        t_word b_ra, b_rv, b_ga, b_gv, s_ra, s_rv, s_ga, s_gv;
        t_word racc, gacc, drv, dra, dgv, dga, ts;
        t_out_item r;
        if (it.kind) begin
            st_rv = it.initial_rotor_speed;
            st_ra = '0;
            st_ga = '0;
            st_gv = (cfg_val[REG_MODE] != 0) ? t_word'(0)
                                             : qmul(it.initial_rotor_speed, cfg_val[REG_GR]);
        end else begin
            ts = cfg_val[REG_TS];
            b_ra = st_ra; b_rv = st_rv; b_ga = st_ga; b_gv = st_gv;
            s_ra = '0; s_rv = '0; s_ga = '0; s_gv = '0;
            for (int k = 0; k < 4; k++) begin
                shaft_accel(b_ra, b_rv, b_ga, b_gv, it.rotor_tq, it.gen_tq, racc, gacc);
                drv = qmul(racc, ts);
                dra = qmul(b_rv, ts);
                dgv = qmul(gacc, ts);
                dga = qmul(b_gv, ts);
                // middle stages count twice
                for (int w = 0; w < ((k == 1 || k == 2) ? 2 : 1); w++) begin
                    s_rv = qadd(s_rv, drv);
                    s_ra = qadd(s_ra, dra);
                    s_gv = qadd(s_gv, dgv);
                    s_ga = qadd(s_ga, dga);
                end
                if (k < 2) begin
                    drv = qmul(drv, HALF_C);
                    dra = qmul(dra, HALF_C);
                    dgv = qmul(dgv, HALF_C);
                    dga = qmul(dga, HALF_C);
                end
                b_rv = qadd(st_rv, drv);
                b_ra = qadd(st_ra, dra);
                b_gv = qadd(st_gv, dgv);
                b_ga = qadd(st_ga, dga);
            end
            st_rv = qadd(st_rv, qmul(s_rv, SIXTH));
            st_ra = qadd(st_ra, qmul(s_ra, SIXTH));
            st_gv = qadd(st_gv, qmul(s_gv, SIXTH));
            st_ga = qadd(st_ga, qmul(s_ga, SIXTH));
        end
        r.rotor_angle = st_ra;
        r.rotor_speed = st_rv;
        r.gen_angle   = st_ga;
        r.gen_speed   = st_gv;
        return r;
    endfunction

    function automatic t_word rnd48();
        return t_word'({$urandom, $urandom});
    endfunction

    // mostly moderate magnitudes, sometimes the full word
    function automatic t_word rnd_val();
        if ($urandom_range(99) < 25) return rnd48();
        return t_word'($signed(32'($urandom)) >>> $urandom_range(31));
    endfunction

    // setup then access phase; the caller ends the transfer
    task automatic reg_write(input logic [2:0] idx, input logic [63:0] val);
        logic [63:0] mask;
        mask = (64'd1 << REG_WIDTH[idx]) - 64'd1;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        cfg_val[idx] = t_word'(val & mask);
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (shaft_q.size() != 0) @(posedge i_clk);
        repeat (5) @(posedge i_clk);
    endtask

    task automatic set_model(input logic m, input logic [63:0] ts, gr, igr, k, d, iri, igi);
        wait_drained();
        reg_write(REG_MODE, 64'(m));
        reg_write(REG_TS, ts);
        reg_write(REG_GR, gr);
        reg_write(REG_IGR, igr);
        reg_write(REG_K, k);
        reg_write(REG_D, d);
        reg_write(REG_IRI, iri);
        reg_write(REG_IGI, igi);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic send_item(input t_in_item it);
        i_in_valid <= 1'b1;
        i_in_item  <= it;
        do @(posedge i_clk); while (o_in_stall);
        shaft_q.push_back(advance_shafts(it));
        if (!calm && $urandom_range(99) < 25) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
        end
    endtask

    task automatic send_step(input t_word rt, input t_word gt);
        t_in_item it;
        it = '{kind: 1'b0, rotor_tq: rt, gen_tq: gt, initial_rotor_speed: rnd48()};
        send_item(it);
    endtask

    task automatic send_load(input t_word spd);
        t_in_item it;
        it = '{kind: 1'b1, rotor_tq: rnd48(), gen_tq: rnd48(), initial_rotor_speed: spd};
        send_item(it);
    endtask

    function automatic logic [63:0] rnd_cfg47();
        return 64'({$urandom, $urandom}) & ((64'd1 << CFG_W) - 64'd1);
    endfunction

    // reset values: constant speed, zero step, so angles stay put
    task automatic test_reset_defaults();
        send_step(VMAX, VMIN);
        send_load(t_word'(ONE));
        send_step(VMIN, VMAX);
        send_load(VMIN);
    endtask

    task automatic test_constant_speed();
        set_model(1'b1, 64'(ONE), 64'(ONE) * 2, 64'(ONE) / 2, 0, 0, 64'(ONE), 64'(ONE));
        send_load(t_word'(ONE) * 3);
        send_step(0, 0);
        send_step(VMAX, VMAX);
        send_load(VMAX);
        send_step(0, 0);
        send_step(0, 0);
    endtask

    task automatic test_dynamic();
        calm = 1'b1;
        set_model(1'b0, 64'd16777, 64'(ONE) * 3, 64'(ONE) / 3, 64'(ONE) * 50,
                  64'(ONE) / 4, 64'(ONE) / 10, 64'(ONE) / 2);
        send_load(t_word'(ONE) * 2);
        for (int i = 0; i < 5; i++) send_step(t_word'(ONE) * 10, -t_word'(ONE) * 2);
        send_load(-t_word'(ONE));
        send_step(VMIN, VMIN);
        calm = 1'b0;
    endtask

    task automatic test_extremes();
        logic [63:0] big;
        big = (64'd1 << CFG_W) - 64'd1;
        set_model(1'b0, 64'(ONE), big, big, big, big, big, big);
        send_load(VMAX);
        send_step(VMAX, VMIN);
        send_step(VMIN, VMAX);
        set_model(1'b0, 0, 0, 0, 0, 0, 0, 0);
        send_load(VMIN);
        send_step(VMAX, VMAX);
    endtask

    task automatic test_random(input int n_items);
        int sent;
        sent = 0;
        while (sent < n_items) begin
            if ($urandom_range(3) == 0)
                set_model(1'($urandom_range(1)), 64'($urandom_range(32'h100_0000)),
                          rnd_cfg47(), rnd_cfg47(), rnd_cfg47(), rnd_cfg47(),
                          rnd_cfg47(), rnd_cfg47());
            else
                set_model(1'($urandom_range(3) == 0), 64'($urandom_range(200000)),
                          64'($urandom_range(32'h1000_0000)), 64'($urandom_range(32'h200_0000)),
                          64'($urandom_range(32'h4000_0000)), 64'($urandom_range(32'h400_0000)),
                          64'($urandom_range(32'h200_0000)), 64'($urandom_range(32'h200_0000)));
            send_load(rnd_val());
            sent++;
            for (int i = 0; i < 40 && sent < n_items; i++) begin
                if ($urandom_range(9) == 0) send_load(rnd_val());
                else send_step(rnd_val(), rnd_val());
                sent++;
            end
        end
    endtask

    // output stall and result check
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            i_out_stall <= !calm && ($urandom_range(99) < 25);
        end
    end

    always @(posedge i_clk) begin
        t_out_item exp_r;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (shaft_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result item %h", o_out_item);
            end else begin
                exp_r = shaft_q.pop_front();
                if (o_out_item !== exp_r) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: ra %h/%h rv %h/%h ga %h/%h gv %h/%h (exp/act)",
                                 exp_r.rotor_angle, o_out_item.rotor_angle,
                                 exp_r.rotor_speed, o_out_item.rotor_speed,
                                 exp_r.gen_angle, o_out_item.gen_angle,
                                 exp_r.gen_speed, o_out_item.gen_speed);
                end
            end
        end
    end

    // watchdog on cycles without any accepted item or taken result
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) || !i_rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WDOG_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial begin
        cfg_val = '{t_word'(1), t_word'(0), t_word'(ONE), t_word'(ONE),
                    t_word'(0), t_word'(0), t_word'(ONE), t_word'(ONE)};
        st_ra = '0; st_rv = '0; st_ga = '0; st_gv = '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_defaults();
        test_constant_speed();
        test_dynamic();
        test_extremes();
        test_random(430);
        wait_drained();
        repeat (50) @(posedge i_clk);
        if (mismatches == 0 && shaft_q.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

@@ two_mass_drivetrain_rk4_step.f @@
+incdir+design
design/tmdrk_pkg.sv
design/two_mass_drivetrain_rk4_step.sv
tb/sv/testbench.sv
